// File: hw/rtl/utf8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies.
package utf8sd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int COUNT_W = 32;
    localparam int KIND_W  = 2;
    localparam int PEND_W  = 3;
    localparam int DATA_W  = 7;
    localparam int CONT_W  = 6;

    localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
    localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD5_MIN = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD6_MIN = 8'hFC;
    localparam logic [BYTE_W-1:0] BAD_HIGH  = 8'hFE;
    localparam logic [BYTE_W-1:0] TAG_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_CONT = 8'h3F;
    localparam logic [BYTE_W-1:0] MASK_L2   = 8'h1F;
    localparam logic [BYTE_W-1:0] MASK_L3   = 8'h0F;
    localparam logic [BYTE_W-1:0] MASK_L4   = 8'h07;
    localparam logic [BYTE_W-1:0] MASK_L5   = 8'h03;
    localparam logic [BYTE_W-1:0] MASK_L6   = 8'h01;

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD,
        CLS_BAD
    } byte_cls_t;

    typedef struct packed {
        byte_cls_t         cls;
        logic [PEND_W-1:0] pend;
        logic [DATA_W-1:0] data;
    } item_t;

endpackage

// File: hw/rtl/utf8sd_front.sv
// Front stage: accepts bytes and classifies them into decoded items.
// Depends on utf8sd_pkg.
module utf8sd_front
    import utf8sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] in_byte,
    output logic              item_valid,
    output item_t             item,
    input  logic              item_full
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign in_stall   = valid_reg && item_full;
    assign take       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.pend = '0;
        item_next.data = in_byte[DATA_W-1:0];
        if (in_byte == '0)
        begin
            item_next.cls = CLS_ZERO;
        end
        else if (in_byte < CONT_TAG)
        begin
            item_next.cls = CLS_ASCII;
        end
        else if ((in_byte & TAG_MASK) == CONT_TAG)
        begin
            item_next.cls  = CLS_CONT;
            item_next.data = DATA_W'(in_byte & MASK_CONT);
        end
        else if (in_byte < LEAD2_MIN || in_byte >= BAD_HIGH)
        begin
            item_next.cls = CLS_BAD;
        end
        else
        begin
            item_next.cls = CLS_LEAD;
            if (in_byte < LEAD3_MIN)
            begin
                item_next.pend = PEND_W'(1);
                item_next.data = DATA_W'(in_byte & MASK_L2);
            end
            else if (in_byte < LEAD4_MIN)
            begin
                item_next.pend = PEND_W'(2);
                item_next.data = DATA_W'(in_byte & MASK_L3);
            end
            else if (in_byte < LEAD5_MIN)
            begin
                item_next.pend = PEND_W'(3);
                item_next.data = DATA_W'(in_byte & MASK_L4);
            end
            else if (in_byte < LEAD6_MIN)
            begin
                item_next.pend = PEND_W'(4);
                item_next.data = DATA_W'(in_byte & MASK_L5);
            end
            else
            begin
                item_next.pend = PEND_W'(5);
                item_next.data = DATA_W'(in_byte & MASK_L6);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!item_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: hw/rtl/utf8sd_queue.sv
// Short FIFO of classified items between front and back stages.
// Depends on utf8sd_pkg.
module utf8sd_queue
    import utf8sd_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    output logic  head_valid,
    output item_t head_item,
    input  logic  pop
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    item_t            entries [Depth];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_next;
    logic [CntW-1:0]  count_reg;
    logic [CntW-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/utf8sd_back.sv
// Back stage: sequence state, code point accumulation, counting, result register.
// Depends on utf8sd_pkg.
module utf8sd_back
    import utf8sd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  item_t              head_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [CP_W-1:0]    code_point,
    output logic [COUNT_W-1:0] char_count
);

    logic [PEND_W-1:0]  pend_reg;
    logic [PEND_W-1:0]  pend_next;
    logic [CP_W-1:0]    acc_reg;
    logic [CP_W-1:0]    acc_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               discard_reg;
    logic               discard_next;
    logic               ovalid_reg;
    logic               ovalid_next;
    kind_t              kind_reg;
    kind_t              kind_next;
    logic [CP_W-1:0]    cp_reg;
    logic [CP_W-1:0]    cp_next;
    logic [COUNT_W-1:0] ocnt_reg;
    logic [COUNT_W-1:0] ocnt_next;
    logic               emit;
    logic [COUNT_W-1:0] cnt_inc;
    logic [CP_W-1:0]    acc_shift;

    assign pop        = head_valid && (!ovalid_reg || !out_stall);
    assign out_valid  = ovalid_reg;
    assign kind       = kind_reg;
    assign code_point = cp_reg;
    assign char_count = ocnt_reg;

    assign cnt_inc   = (cnt_reg == '1) ? cnt_reg : cnt_reg + COUNT_W'(1);
    assign acc_shift = {acc_reg[CP_W-CONT_W-1:0], head_item.data[CONT_W-1:0]};

    always_comb
    begin
        pend_next    = pend_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        kind_next    = KIND_ERROR;
        cp_next      = '0;
        ocnt_next    = cnt_reg;
        if (discard_reg)
        begin
            if (head_item.cls == CLS_ZERO)
            begin
                discard_next = 1'b0;
                cnt_next     = '0;
                pend_next    = '0;
                acc_next     = '0;
            end
        end
        else if (pend_reg != '0)
        begin
            case (head_item.cls)
                CLS_ZERO:
                begin
                    emit      = 1'b1;
                    cnt_next  = '0;
                    pend_next = '0;
                    acc_next  = '0;
                end
                CLS_CONT:
                begin
                    pend_next = pend_reg - PEND_W'(1);
                    acc_next  = acc_shift;
                    if (pend_reg == PEND_W'(1))
                    begin
                        emit      = 1'b1;
                        kind_next = KIND_CHAR;
                        cp_next   = acc_shift;
                        cnt_next  = cnt_inc;
                        ocnt_next = cnt_inc;
                        acc_next  = '0;
                    end
                end
                default:
                begin
                    emit         = 1'b1;
                    pend_next    = '0;
                    acc_next     = '0;
                    discard_next = 1'b1;
                end
            endcase
        end
        else
        begin
            case (head_item.cls)
                CLS_ZERO:
                begin
                    emit      = 1'b1;
                    kind_next = KIND_END;
                    cnt_next  = '0;
                    pend_next = '0;
                    acc_next  = '0;
                end
                CLS_ASCII:
                begin
                    emit      = 1'b1;
                    kind_next = KIND_CHAR;
                    cp_next   = CP_W'(head_item.data);
                    cnt_next  = cnt_inc;
                    ocnt_next = cnt_inc;
                end
                CLS_LEAD:
                begin
                    pend_next = head_item.pend;
                    acc_next  = CP_W'(head_item.data);
                end
                default:
                begin
                    emit         = 1'b1;
                    pend_next    = '0;
                    acc_next     = '0;
                    discard_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        ovalid_next = ovalid_reg && out_stall;
        if (pop && emit)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            discard_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (pop)
            begin
                pend_reg    <= pend_next;
                acc_reg     <= acc_next;
                cnt_reg     <= cnt_next;
                discard_reg <= discard_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg <= kind_next;
            cp_reg   <= cp_next;
            ocnt_reg <= ocnt_next;
        end
    end

endmodule

// File: hw/rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: front classifier, item queue, back stage.
// Depends on utf8sd_pkg, utf8sd_front, utf8sd_queue, utf8sd_back.
//
// Decodes one byte of a zero-terminated UTF-8 string (up to six-byte form,
// 31-bit code points) per cycle unless stalled. Each byte yields at most
// one result: a character, the end-of-string count, or one error after
// which bytes are dropped up to the next zero byte. Sustained rate is one
// byte per clock while the output does not stall; the back stage updates
// its sequence state once per byte. Bytes pass through the classify
// register, then the queue, and the result register loads as the item
// leaves the queue. The queue holds QueueDepth items so that input keeps
// flowing for a while when the output side stalls.
module utf8_stream_decoder_unit
    import utf8sd_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [BYTE_W-1:0]  in_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind,
    output logic [CP_W-1:0]    code_point,
    output logic [COUNT_W-1:0] char_count
);

    logic  f_valid;
    item_t f_item;
    logic  q_full;
    logic  q_valid;
    item_t q_item;
    logic  q_pop;

    utf8sd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .item_valid (f_valid),
        .item       (f_item),
        .item_full  (q_full)
    );

    utf8sd_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_valid),
        .push_item  (f_item),
        .full       (q_full),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop)
    );

    utf8sd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_item  (q_item),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .code_point (code_point),
        .char_count (char_count)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_stream_decoder_unit: byte stimulus, decoder prediction,
// per-field result checking. Depends on utf8sd_pkg and the decoder RTL.
module tb_top
    import utf8sd_pkg::*;
();

    typedef struct {
        kind_t              kind;
        logic [CP_W-1:0]    cp;
        logic [COUNT_W-1:0] count;
    } decoded_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [BYTE_W-1:0]  in_byte = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  kind;
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] char_count;

    // decoder state mirror
    logic [PEND_W-1:0]  pend_cnt = '0;
    logic [CP_W-1:0]    cp_acc = '0;
    logic [COUNT_W-1:0] str_chars = '0;
    logic               dropping = 1'b0;

    decoded_t           decoded_q [$];
    int                 fails = 0;
    int                 sent_bytes = 0;
    int                 hold_cycles = 0;
    bit                 idle_on = 1'b1;

    utf8_stream_decoder_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .code_point (code_point),
        .char_count (char_count)
    );

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic void push_decoded(input kind_t k, input logic [CP_W-1:0] cp);
        decoded_t d;
        d.kind = k;
        d.cp = cp;
        d.count = str_chars;
        decoded_q.push_back(d);
    endfunction

    function automatic void bump_chars();
        if (str_chars != '1)
            str_chars = str_chars + 1'b1;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        sent_bytes++;
        if (dropping)
        begin
            if (b == '0)
            begin
                dropping = 1'b0;
                str_chars = '0;
                pend_cnt = '0;
                cp_acc = '0;
            end
            return;
        end
        if (pend_cnt != '0)
        begin
            if (b == '0)
            begin
                push_decoded(KIND_ERROR, '0);
                str_chars = '0;
                pend_cnt = '0;
                cp_acc = '0;
            end
            else if ((b & TAG_MASK) != CONT_TAG)
            begin
                push_decoded(KIND_ERROR, '0);
                pend_cnt = '0;
                cp_acc = '0;
                dropping = 1'b1;
            end
            else
            begin
                cp_acc = {cp_acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
                pend_cnt = pend_cnt - 1'b1;
                if (pend_cnt == '0)
                begin
                    bump_chars();
                    push_decoded(KIND_CHAR, cp_acc);
                    cp_acc = '0;
                end
            end
            return;
        end
        if (b == '0)
        begin
            push_decoded(KIND_END, '0);
            str_chars = '0;
            cp_acc = '0;
        end
        else if (b < CONT_TAG)
        begin
            bump_chars();
            push_decoded(KIND_CHAR, CP_W'(b));
        end
        else if (b < LEAD2_MIN || b >= BAD_HIGH)
        begin
            push_decoded(KIND_ERROR, '0);
            cp_acc = '0;
            dropping = 1'b1;
        end
        else if (b < LEAD3_MIN)
        begin
            pend_cnt = 3'd1;
            cp_acc = CP_W'(b & MASK_L2);
        end
        else if (b < LEAD4_MIN)
        begin
            pend_cnt = 3'd2;
            cp_acc = CP_W'(b & MASK_L3);
        end
        else if (b < LEAD5_MIN)
        begin
            pend_cnt = 3'd3;
            cp_acc = CP_W'(b & MASK_L4);
        end
        else if (b < LEAD6_MIN)
        begin
            pend_cnt = 3'd4;
            cp_acc = CP_W'(b & MASK_L5);
        end
        else
        begin
            pend_cnt = 3'd5;
            cp_acc = CP_W'(b & MASK_L6);
        end
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
    endtask

    // lead byte for a len-byte form, followed by ncont random continuation bytes
    task automatic send_char(input int len, input int ncont);
        logic [BYTE_W-1:0] lead;
        logic [BYTE_W-1:0] cont;
        case (len)
            1: lead = BYTE_W'($urandom_range(1, CONT_TAG - 1));
            2: lead = BYTE_W'($urandom_range(LEAD2_MIN, LEAD3_MIN - 1));
            3: lead = BYTE_W'($urandom_range(LEAD3_MIN, LEAD4_MIN - 1));
            4: lead = BYTE_W'($urandom_range(LEAD4_MIN, LEAD5_MIN - 1));
            5: lead = BYTE_W'($urandom_range(LEAD5_MIN, LEAD6_MIN - 1));
            default: lead = BYTE_W'($urandom_range(LEAD6_MIN, BAD_HIGH - 1));
        endcase
        send_byte(lead);
        repeat (ncont)
        begin
            cont = BYTE_W'($urandom_range(0, 8'hFF));
            send_byte(CONT_TAG | (cont & MASK_CONT));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_valid_forms();
        logic [BYTE_W-1:0] seq [$];
        seq = '{8'h00, 8'h01, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // bad lead, top bad lead, bad continuation, zero inside a sequence
    task automatic test_invalid_bytes();
        logic [BYTE_W-1:0] seq [$];
        seq = '{8'h80, 8'h41, 8'h00, 8'hFE, 8'h00, 8'hE0, 8'hC0, 8'h00,
                8'hF0, 8'h80, 8'h00};
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        hold_cycles = 150;
        repeat (64)
            send_byte(BYTE_W'(8'h41 + $urandom_range(0, 25)));
        send_byte(8'h00);
        wait_drained();
        idle_on = 1'b1;
        send_char(3, 2);
        send_char(4, 1);
        wait_drained();
        send_char(4, 0);
        wait_drained();
        send_byte(CONT_TAG);
        send_byte(8'h00);
        wait_drained();
    endtask

    task automatic test_random_strings();
        int stop_at;
        int pick;
        int n;
        int len;
        logic [BYTE_W-1:0] b;
        stop_at = 1400;
        while (sent_bytes < stop_at)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                n = $urandom_range(0, 8);
                repeat (n)
                begin
                    len = $urandom_range(1, 6);
                    send_char(len, len - 1);
                end
                send_byte(8'h00);
            end
            else if (pick < 9)
            begin
                n = $urandom_range(0, 3);
                repeat (n)
                begin
                    len = $urandom_range(1, 6);
                    send_char(len, len - 1);
                end
                len = $urandom_range(2, 6);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        send_char(len, $urandom_range(0, len - 2));
                    end
                    1:
                    begin
                        send_char(len, $urandom_range(0, len - 2));
                        b = BYTE_W'($urandom_range(1, 8'hFF));
                        while ((b & TAG_MASK) == CONT_TAG)
                            b = BYTE_W'($urandom_range(1, 8'hFF));
                        send_byte(b);
                    end
                    default:
                    begin
                        if ($urandom_range(0, 1) != 0)
                            send_byte(BYTE_W'($urandom_range(CONT_TAG, LEAD2_MIN - 1)));
                        else
                            send_byte(BYTE_W'($urandom_range(BAD_HIGH, 8'hFF)));
                    end
                endcase
                n = $urandom_range(0, 4);
                repeat (n)
                    send_byte(BYTE_W'($urandom_range(1, 8'hFF)));
                send_byte(8'h00);
            end
            else
            begin
                n = $urandom_range(1, 12);
                repeat (n)
                    send_byte(BYTE_W'($urandom_range(0, 8'hFF)));
                send_byte(8'h00);
            end
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = idle_on ? $urandom_range(0, 14) : 0;
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        decoded_t d;
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: kind %0d code_point %0h char_count %0d",
                       kind, code_point, char_count);
                fails++;
            end
            else
            begin
                d = decoded_q.pop_front();
                if (kind !== d.kind)
                begin
                    $error("kind: expected %0d, got %0d", d.kind, kind);
                    fails++;
                end
                if (code_point !== d.cp)
                begin
                    $error("code_point: expected %0h, got %0h", d.cp, code_point);
                    fails++;
                end
                if (char_count !== d.count)
                begin
                    $error("char_count: expected %0d, got %0d", d.count, char_count);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_valid_forms();
        wait_drained();
        test_invalid_bytes();
        wait_drained();
        test_backpressure();
        test_random_strings();
        wait_drained();
        repeat (8) @(posedge clk);
        if (fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
